// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during rst
`define RAQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("raq: same-cycle check failed");
// next-cycle implication, sampled on clk, off during rst
`define RAQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("raq: next-cycle check failed");
`else
`define RAQ_ASSERT_NOW(lbl, ante, cons)
`define RAQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/raq_pkg.sv =====
// ----------------------------------------------------------------------------
// raq_pkg
// Sizes, codes and request types of the range-assign / point-query store.
// ----------------------------------------------------------------------------
package raq_pkg;

  // Store geometry. BUCKET_SIZE is a power of two.
  localparam int ENTRIES     = 4096;
  localparam int BUCKET_SIZE = 64;
  localparam int BUCKETS     = (ENTRIES + BUCKET_SIZE - 1) / BUCKET_SIZE;

  // Field widths
  localparam int IDX_W = 12;
  localparam int VAL_W = 31;

  // Derived widths
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int OFF_W  = $clog2(BUCKET_SIZE);
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int POS_W  = BKT_W + OFF_W;
  localparam int CMP_W  = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  localparam logic [VAL_W-1:0] VALUE_MAX  = {VAL_W{1'b1}};
  localparam logic [POS_W-1:0] LAST_ENTRY = POS_W'(ENTRIES - 1);

  // Operation codes
  localparam logic OP_ASSIGN = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Tag store request
  typedef struct packed {
    logic             rd_en;
    logic [BKT_W-1:0] rd_bkt;
    logic             set_en;   // whole-bucket assign: tag pending
    logic             clr_en;   // tag pushed into the elements
    logic [BKT_W-1:0] wr_bkt;
    logic [VAL_W-1:0] value;
  } tag_req_t;

  // Tag store response, for the bucket of the latest read request
  typedef struct packed {
    logic             pending;
    logic [VAL_W-1:0] value;
  } tag_rsp_t;

  // Element store request, one port
  typedef struct packed {
    logic              en;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } elem_req_t;

endpackage

// ===== rtl/raq_tag_store.sv =====
// ----------------------------------------------------------------------------
// raq_tag_store
// Per-bucket pending tags: value memory plus pending and fresh flags.
// ----------------------------------------------------------------------------
module raq_tag_store (
  input  logic              clk,
  input  logic              rst,
  input  raq_pkg::tag_req_t req,
  output raq_pkg::tag_rsp_t rsp
);

  logic [raq_pkg::VAL_W-1:0] tag_mem [raq_pkg::BUCKETS];
  logic [raq_pkg::VAL_W-1:0] mem_q;
  logic [raq_pkg::BKT_W-1:0] rd_bkt_q;

  // pending: tag not yet pushed; fresh: bucket still holds its reset value.
  // After reset every bucket acts as if tagged with the reset value.
  logic [raq_pkg::BUCKETS-1:0] pending;
  logic [raq_pkg::BUCKETS-1:0] fresh;

  // value memory, registered read
  always_ff @(posedge clk) begin
    if (req.set_en) begin
      tag_mem[req.wr_bkt] <= req.value;
    end
    if (req.rd_en) begin
      mem_q    <= tag_mem[req.rd_bkt];
      rd_bkt_q <= req.rd_bkt;
    end
  end

  // flags
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '1;
      fresh   <= '1;
    end else if (req.set_en) begin
      pending[req.wr_bkt] <= 1'b1;
      fresh[req.wr_bkt]   <= 1'b0;
    end else if (req.clr_en) begin
      pending[req.wr_bkt] <= 1'b0;
      fresh[req.wr_bkt]   <= 1'b0;
    end
  end

  assign rsp.pending = pending[rd_bkt_q];
  assign rsp.value   = fresh[rd_bkt_q] ? raq_pkg::VALUE_MAX : mem_q;

endmodule

// ===== rtl/raq_elem_store.sv =====
// ----------------------------------------------------------------------------
// raq_elem_store
// Element memory, single port, registered read.
// ----------------------------------------------------------------------------
module raq_elem_store (
  input  logic                      clk,
  input  raq_pkg::elem_req_t        req,
  output logic [raq_pkg::VAL_W-1:0] q
);

  logic [raq_pkg::VAL_W-1:0] elem_mem [raq_pkg::ENTRIES];

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        elem_mem[req.addr] <= req.data;
      end else begin
        q <= elem_mem[req.addr];
      end
    end
  end

endmodule

// ===== rtl/range_assign_point_query_unit.sv =====
// ----------------------------------------------------------------------------
// range_assign_point_query_unit
// Bucketed store with range assign and point read, one item at a time.
// ----------------------------------------------------------------------------
// Items are taken one at a time; the element memory port sets the pace.
// A read looks up its bucket's tag and, if one is pending, returns it and
// pushes it into the bucket's elements, else reads the element. An assign
// tags each bucket wholly inside the range and sweeps each partly covered
// bucket (at most two), pushing any pending tag and writing the covered
// elements; an assign with first_index above last_index or beyond the store
// changes nothing. A read result waits in a two-deep output path, so the
// next item is taken while it is still stalled. No clearing pass follows
// reset: each bucket starts as if tagged with the reset value.
module range_assign_point_query_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic [raq_pkg::IDX_W-1:0] first_index,
  input  logic [raq_pkg::IDX_W-1:0] last_index,
  input  logic [raq_pkg::VAL_W-1:0] write_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [raq_pkg::VAL_W-1:0] read_value
);

  `include "assert_macros.svh"

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BKT   = 3'd1;
  localparam logic [2:0] ST_TAGRD = 3'd2;
  localparam logic [2:0] ST_SWEEP = 3'd3;
  localparam logic [2:0] ST_ELRD  = 3'd4;

  logic [2:0]                 state;
  logic                       op;
  logic [raq_pkg::ADDR_W-1:0] lo;
  logic [raq_pkg::ADDR_W-1:0] hi;
  logic [raq_pkg::VAL_W-1:0]  value;
  logic [raq_pkg::BKT_W-1:0]  bkt;
  logic [raq_pkg::BKT_W-1:0]  bhi;
  logic [raq_pkg::OFF_W-1:0]  off;
  logic                       push;
  logic [raq_pkg::VAL_W-1:0]  tagv;
  logic                       res_pend;
  logic [raq_pkg::VAL_W-1:0]  res_val;

  raq_pkg::tag_req_t  tag_req;
  raq_pkg::tag_rsp_t  tag_rsp;
  raq_pkg::elem_req_t elem_req;
  logic [raq_pkg::VAL_W-1:0] elem_q;

  logic in_accept;
  logic out_load;

  // decode of the incoming item
  logic [raq_pkg::CMP_W-1:0]  first_c;
  logic [raq_pkg::CMP_W-1:0]  last_c;
  logic [raq_pkg::CMP_W-1:0]  hi_clip;
  logic                       lo_ok;
  logic                       range_ok;
  logic [raq_pkg::POS_W-1:0]  lo_pos_in;
  logic [raq_pkg::POS_W-1:0]  hi_pos_in;

  // current bucket geometry
  logic [raq_pkg::POS_W-1:0] start_pos;
  logic [raq_pkg::POS_W-1:0] top_pos;
  logic [raq_pkg::POS_W-1:0] end_pos;
  logic [raq_pkg::POS_W-1:0] cur_pos;
  logic                      full;
  logic                      sweep_last;
  logic                      in_rng;

  assign in_stall  = (state != ST_IDLE) || res_pend;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = res_pend && (!out_valid || !out_stall);

  always_comb begin
    first_c   = raq_pkg::CMP_W'(first_index);
    last_c    = raq_pkg::CMP_W'(last_index);
    lo_ok     = first_c < raq_pkg::CMP_W'(raq_pkg::ENTRIES);
    range_ok  = lo_ok && (first_c <= last_c);
    hi_clip   = (last_c >= raq_pkg::CMP_W'(raq_pkg::ENTRIES)) ?
                raq_pkg::CMP_W'(raq_pkg::ENTRIES - 1) : last_c;
    lo_pos_in = raq_pkg::POS_W'(first_c[raq_pkg::ADDR_W-1:0]);
    hi_pos_in = raq_pkg::POS_W'(hi_clip[raq_pkg::ADDR_W-1:0]);
  end

  // bucket bounds, clipped at the store end
  always_comb begin
    start_pos  = {bkt, {raq_pkg::OFF_W{1'b0}}};
    top_pos    = {bkt, {raq_pkg::OFF_W{1'b1}}};
    end_pos    = (top_pos > raq_pkg::LAST_ENTRY) ? raq_pkg::LAST_ENTRY : top_pos;
    cur_pos    = {bkt, off};
    full       = (raq_pkg::POS_W'(lo) <= start_pos) && (raq_pkg::POS_W'(hi) >= end_pos);
    sweep_last = cur_pos == end_pos;
    in_rng     = (op == raq_pkg::OP_ASSIGN) && (cur_pos >= raq_pkg::POS_W'(lo)) &&
                 (cur_pos <= raq_pkg::POS_W'(hi));
  end

  // tag store requests
  always_comb begin
    tag_req        = '0;
    tag_req.wr_bkt = bkt;
    tag_req.value  = value;
    tag_req.rd_bkt = bkt;
    case (state)
      ST_IDLE: begin
        tag_req.rd_bkt = lo_pos_in[raq_pkg::POS_W-1:raq_pkg::OFF_W];
        tag_req.rd_en  = in_accept && (operation == raq_pkg::OP_READ) && lo_ok;
      end
      ST_BKT: begin
        tag_req.set_en = full;
        tag_req.rd_en  = !full;
      end
      ST_TAGRD: begin
        tag_req.clr_en = tag_rsp.pending;
      end
      default: begin
      end
    endcase
  end

  // element store requests
  always_comb begin
    elem_req      = '0;
    elem_req.addr = cur_pos[raq_pkg::ADDR_W-1:0];
    elem_req.data = in_rng ? value : tagv;
    case (state)
      ST_TAGRD: begin
        elem_req.addr = lo;
        elem_req.en   = (op == raq_pkg::OP_READ) && !tag_rsp.pending;
      end
      ST_SWEEP: begin
        elem_req.en = in_rng || push;
        elem_req.we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      res_pend <= 1'b0;
    end else begin
      if (out_load) begin
        res_pend <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            op    <= operation;
            lo    <= first_c[raq_pkg::ADDR_W-1:0];
            hi    <= hi_clip[raq_pkg::ADDR_W-1:0];
            value <= write_value;
            bkt   <= lo_pos_in[raq_pkg::POS_W-1:raq_pkg::OFF_W];
            bhi   <= hi_pos_in[raq_pkg::POS_W-1:raq_pkg::OFF_W];
            if (operation == raq_pkg::OP_READ) begin
              if (lo_ok) begin
                state <= ST_TAGRD;
              end else begin
                res_val  <= '0;
                res_pend <= 1'b1;
              end
            end else if (range_ok) begin
              state <= ST_BKT;
            end
          end
        end
        ST_BKT: begin
          if (!full) begin
            state <= ST_TAGRD;
          end else if (bkt == bhi) begin
            state <= ST_IDLE;
          end else begin
            bkt <= bkt + raq_pkg::BKT_W'(1);
          end
        end
        ST_TAGRD: begin
          push <= tag_rsp.pending;
          tagv <= tag_rsp.value;
          off  <= '0;
          if (op == raq_pkg::OP_READ) begin
            if (tag_rsp.pending) begin
              res_val  <= tag_rsp.value;
              res_pend <= 1'b1;
              state    <= ST_SWEEP;
            end else begin
              state <= ST_ELRD;
            end
          end else begin
            state <= ST_SWEEP;
          end
        end
        ST_SWEEP: begin
          off <= off + raq_pkg::OFF_W'(1);
          if (sweep_last) begin
            if ((op == raq_pkg::OP_READ) || (bkt == bhi)) begin
              state <= ST_IDLE;
            end else begin
              bkt   <= bkt + raq_pkg::BKT_W'(1);
              state <= ST_BKT;
            end
          end
        end
        ST_ELRD: begin
          res_val  <= elem_q;
          res_pend <= 1'b1;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= 1'b1;
      read_value <= res_val;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  raq_tag_store u_tag (
    .clk (clk),
    .rst (rst),
    .req (tag_req),
    .rsp (tag_rsp)
  );

  raq_elem_store u_elem (
    .clk (clk),
    .req (elem_req),
    .q   (elem_q)
  );

  // an assign never leaves a result behind
  `RAQ_ASSERT_NEXT(a_assign_no_result, in_accept && (operation == raq_pkg::OP_ASSIGN), !res_pend)
  // an element read always ends the item with a result
  `RAQ_ASSERT_NEXT(a_elrd_result, state == ST_ELRD, res_pend && (state == ST_IDLE))
  // sweep stays inside the store and the current bucket
  `RAQ_ASSERT_NOW(a_sweep_bound, state == ST_SWEEP, cur_pos <= end_pos)
  // a waiting result moves on once the output is free
  `RAQ_ASSERT_NEXT(a_result_moves, out_load, out_valid && (read_value == $past(res_val)))

endmodule

// ===== tb/range_assign_point_query_checker.sv =====
// ----------------------------------------------------------------------------
// range_assign_point_query_checker
// Watches both channels of the bucketed range-assign / point-read store,
// keeps a shadow copy of its elements and bucket tags, predicts each read
// result and compares it with what the block returns.
// ----------------------------------------------------------------------------
module range_assign_point_query_checker
  import raq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             operation,
  input  logic [IDX_W-1:0] first_index,
  input  logic [IDX_W-1:0] last_index,
  input  logic [VAL_W-1:0] write_value,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [VAL_W-1:0] read_value,
  output int               mismatch_count,
  output int               reads_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow store: elements plus one pending tag per bucket
  logic [VAL_W-1:0] shadow_elem    [ENTRIES];
  logic             shadow_tag_set [BUCKETS];
  logic [VAL_W-1:0] shadow_tag_val [BUCKETS];

  // Read values still owed by the block, oldest first
  logic [VAL_W-1:0] expected_reads [$];

  initial begin
    mismatch_count  = 0;
    reads_in_flight = 0;
  end

  task automatic report_mismatch(input string what, input logic [VAL_W-1:0] want,
                                 input logic [VAL_W-1:0] got);
    $display("mismatch at %0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // One past the last element of bucket b, clipped at the store end
  function automatic int unsigned bucket_limit(input int unsigned b);
    int unsigned lim;
    lim = (b + 1) * BUCKET_SIZE;
    return (lim > ENTRIES) ? ENTRIES : lim;
  endfunction

  // Push a pending tag down into the bucket's elements
  function automatic void flush_bucket(input int unsigned b);
    if (b >= BUCKETS || !shadow_tag_set[b]) return;
    for (int unsigned i = b * BUCKET_SIZE; i < bucket_limit(b); i++)
      shadow_elem[i] = shadow_tag_val[b];
    shadow_tag_set[b] = 1'b0;
  endfunction

  // Range assign: whole buckets get a tag, partial ones are written through
  function automatic void apply_assign(input logic [IDX_W-1:0] lo_idx,
                                       input logic [IDX_W-1:0] hi_idx,
                                       input logic [VAL_W-1:0] v);
    int unsigned lo, hi, s, e;
    lo = lo_idx;
    hi = hi_idx;
    if (lo > hi || lo >= ENTRIES) return;
    if (hi >= ENTRIES) hi = ENTRIES - 1;
    for (int unsigned b = lo / BUCKET_SIZE; b <= hi / BUCKET_SIZE; b++) begin
      s = b * BUCKET_SIZE;
      e = bucket_limit(b);
      if (lo <= s && hi + 1 >= e) begin
        shadow_tag_set[b] = 1'b1;
        shadow_tag_val[b] = v;
      end else begin
        flush_bucket(b);
        if (s < lo) s = lo;
        if (e > hi + 1) e = hi + 1;
        for (int unsigned i = s; i < e; i++)
          shadow_elem[i] = v;
      end
    end
  endfunction

  // Point read; indices past the store end read as zero
  function automatic logic [VAL_W-1:0] predict_read_value(input logic [IDX_W-1:0] idx);
    int unsigned i;
    i = idx;
    if (i >= ENTRIES) return '0;
    flush_bucket(i / BUCKET_SIZE);
    return shadow_elem[i];
  endfunction

  // Channel monitor: results are checked before the new item is predicted
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) shadow_elem[i] = VALUE_MAX;
      for (int b = 0; b < BUCKETS; b++) begin
        shadow_tag_set[b] = 1'b0;
        shadow_tag_val[b] = '0;
      end
      expected_reads.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reads.size() == 0)
          report_mismatch("read result with no read waiting", '0, read_value);
        else if (expected_reads[0] !== read_value)
          report_mismatch("read_value", expected_reads[0], read_value);
        if (expected_reads.size() != 0) void'(expected_reads.pop_front());
      end
      if (in_valid && !in_stall) begin
        if (operation == OP_READ)
          expected_reads.push_back(predict_read_value(first_index));
        else
          apply_assign(first_index, last_index, write_value);
      end
    end
    reads_in_flight = expected_reads.size();
  end

endmodule

// ===== tb/tb_range_assign_point_query_unit.sv =====
// ----------------------------------------------------------------------------
// tb_range_assign_point_query_unit
// Drives directed and random range assigns and point reads into the
// bucketed store, with random idle gaps on input and output, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_range_assign_point_query_unit;
  import raq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 2_000_000;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_stall;
  logic             operation   = OP_READ;
  logic [IDX_W-1:0] first_index = '0;
  logic [IDX_W-1:0] last_index  = '0;
  logic [VAL_W-1:0] write_value = '0;
  logic             out_valid;
  logic             out_stall   = 1'b0;
  logic [VAL_W-1:0] read_value;

  int mismatch_count;
  int reads_in_flight;
  int cycle_count = 0;
  bit quiet       = 1'b0;   // no gaps on either side while set

  range_assign_point_query_unit u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .operation  (operation),
    .first_index(first_index),
    .last_index (last_index),
    .write_value(write_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_value (read_value)
  );

  range_assign_point_query_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .operation      (operation),
    .first_index    (first_index),
    .last_index     (last_index),
    .write_value    (write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_value     (read_value),
    .mismatch_count (mismatch_count),
    .reads_in_flight(reads_in_flight)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_count, reads_in_flight);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Gap length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return VALUE_MAX;
    return VAL_W'($urandom());
  endfunction

  // Present one item after an optional gap and hold it until accepted
  task automatic send_item(input logic op, input int f, input int l,
                           input logic [VAL_W-1:0] v);
    int gap;
    gap = quiet ? 0 : idle_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation   <= op;
    first_index <= IDX_W'(f);
    last_index  <= IDX_W'(l);
    write_value <= v;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Receiver stall pattern: short runs of ready, stalls of random length
  initial begin
    int hold;
    bit stall_now;
    hold = 0;
    stall_now = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        stall_now = !stall_now && !quiet;
        hold = stall_now ? 1 + idle_len() : 1 + $urandom_range(0, 7);
      end
      out_stall <= stall_now;
      hold--;
    end
  end

  // Stimulus and verdict
  initial begin
    int pick, f, l, b0, b1;
    logic op;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset contents, full-store assign, edges and partial buckets
    send_item(OP_READ,   0,    4095, '0);
    send_item(OP_READ,   4095, 0,    VALUE_MAX);
    send_item(OP_ASSIGN, 0,    4095, '0);
    send_item(OP_READ,   0,    0,    '0);
    send_item(OP_READ,   4095, 4095, '0);
    send_item(OP_ASSIGN, 0,    0,    VALUE_MAX);
    send_item(OP_READ,   0,    0,    '0);
    send_item(OP_READ,   1,    0,    '0);
    send_item(OP_ASSIGN, 4095, 4095, VAL_W'(31'h2AAA_AAAA));
    send_item(OP_READ,   4095, 0,    '0);
    send_item(OP_READ,   4094, 0,    '0);
    send_item(OP_ASSIGN, 63,   64,   VAL_W'(31'h5555_5555));
    send_item(OP_READ,   63,   0,    '0);
    send_item(OP_READ,   64,   0,    '0);
    send_item(OP_ASSIGN, 1,    4094, VAL_W'(12345));
    send_item(OP_READ,   2048, 0,    '0);
    send_item(OP_READ,   4094, 0,    '0);
    // reversed range changes nothing
    send_item(OP_ASSIGN, 100,  50,   VALUE_MAX);
    send_item(OP_READ,   75,   0,    '0);
    // aligned single bucket, then a partial write into the tagged bucket
    send_item(OP_ASSIGN, 64,   127,  VAL_W'(777));
    send_item(OP_ASSIGN, 70,   80,   VAL_W'(888));
    send_item(OP_READ,   69,   0,    '0);
    send_item(OP_READ,   75,   0,    '0);
    // tail from a bucket boundary to the store end
    send_item(OP_ASSIGN, 3968, 4095, VALUE_MAX);
    send_item(OP_READ,   3968, 0,    '0);

    // Random: mostly meaningful ranges and reads, some odd ones
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = ((n / 250) % 3) == 2;
      pick = $urandom_range(0, 99);
      op = OP_ASSIGN;
      f = $urandom_range(0, 4095);
      l = $urandom_range(0, 4095);
      if (pick < 35) begin
        op = OP_READ;
      end else if (pick < 45) begin
        op = OP_READ;
        b0 = $urandom_range(0, BUCKETS - 1);
        case ($urandom_range(0, 3))
          0: f = b0 * BUCKET_SIZE;
          1: f = b0 * BUCKET_SIZE + 1;
          2: f = b0 * BUCKET_SIZE + BUCKET_SIZE - 2;
          default: f = b0 * BUCKET_SIZE + BUCKET_SIZE - 1;
        endcase
      end else if (pick < 60) begin
        // inside one bucket
        b0 = $urandom_range(0, BUCKETS - 1);
        f = b0 * BUCKET_SIZE + $urandom_range(0, BUCKET_SIZE - 1);
        l = $urandom_range(f, b0 * BUCKET_SIZE + BUCKET_SIZE - 1);
      end else if (pick < 75) begin
        // partial ends around a few whole buckets
        l = f + $urandom_range(0, 400);
        if (l > ENTRIES - 1) l = ENTRIES - 1;
      end else if (pick < 85) begin
        // whole buckets only
        b0 = $urandom_range(0, BUCKETS - 1);
        b1 = $urandom_range(b0, (b0 + 8 > BUCKETS - 1) ? BUCKETS - 1 : b0 + 8);
        f = b0 * BUCKET_SIZE;
        l = b1 * BUCKET_SIZE + BUCKET_SIZE - 1;
      end else if (pick < 90) begin
        case ($urandom_range(0, 2))
          0: f = 0;
          1: l = ENTRIES - 1;
          default: begin f = 0; l = ENTRIES - 1; end
        endcase
        if (f > l) f = 0;
      end else if (pick < 95) begin
        // reversed range
        f = $urandom_range(1, 4095);
        l = $urandom_range(0, f - 1);
      end
      send_item(op, f, l, pick_value());
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain: every read answered, then let a trailing assign finish
    while (reads_in_flight != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
